// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the keyed cache table RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Types, codes and defaults shared by the keyed cache table modules
// ----------------------------------------------------------------------------
package lfu_pkg;

    // default table depth
    localparam int SLOTS_DEF = 32;

    // field widths
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int LIMIT_W  = 6;

    // capacity limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd32;

    // opcodes
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_GET     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REL_MISS = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd7;

    // one slot read out of the table during a scan
    typedef struct packed {
        logic               live;
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } sample_t;

    // scan summary handed back to the sequencer
    typedef struct packed {
        logic               hit;
        logic               free_found;
        logic               victim_found;
        logic [COUNT_W-1:0] hit_count;
        logic [KEY_W-1:0]   victim_key;
    } scan_res_t;

endpackage

// ===== sv/lfu_scan.sv =====
// ----------------------------------------------------------------------------
// lfu_scan
// Shared compare unit: folds one table slot per cycle into a scan summary
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_scan #(
    parameter int SLOTS = lfu_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS),
    parameter int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lfu_pkg::KEY_W-1:0]   req_key,
    input  lfu_pkg::sample_t            sample,
    input  logic [IDX_W-1:0]            sample_idx,
    output lfu_pkg::scan_res_t          res,
    output logic [IDX_W-1:0]            hit_idx,
    output logic [IDX_W-1:0]            free_idx,
    output logic [IDX_W-1:0]            victim_idx,
    output logic [CNT_W-1:0]            used
);

    logic                          hit_reg, hit_next;
    logic                          free_found_reg, free_found_next;
    logic                          vict_found_reg, vict_found_next;
    logic [IDX_W-1:0]              hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]              free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]              vict_idx_reg, vict_idx_next;
    logic [lfu_pkg::COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [lfu_pkg::COUNT_W-1:0]   vict_cnt_reg, vict_cnt_next;
    logic [lfu_pkg::KEY_W-1:0]     vict_key_reg, vict_key_next;
    logic [CNT_W-1:0]              used_reg, used_next;
    logic                          key_eq;
    logic                          cnt_lt;

    // the shared comparators: key equality and count magnitude
    assign key_eq = (sample.key == req_key);
    assign cnt_lt = (sample.count < vict_cnt_reg);

    // fold one sample into the running summary
    always_comb
    begin
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        vict_found_next = vict_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        vict_idx_next   = vict_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        vict_cnt_next   = vict_cnt_reg;
        vict_key_next   = vict_key_reg;
        used_next       = used_reg;
        if (start)
        begin
            hit_next        = 1'b0;
            free_found_next = 1'b0;
            vict_found_next = 1'b0;
            used_next       = '0;
        end
        else if (sample.live)
        begin
            if (sample.valid)
            begin
                used_next = used_reg + CNT_W'(1);
                // strict less keeps the lowest slot on ties
                if (!vict_found_reg || cnt_lt)
                begin
                    vict_found_next = 1'b1;
                    vict_idx_next   = sample_idx;
                    vict_cnt_next   = sample.count;
                    vict_key_next   = sample.key;
                end
                // first match wins
                if (key_eq && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = sample_idx;
                    hit_cnt_next = sample.count;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = sample_idx;
            end
        end
    end

    // control flags and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            vict_found_reg <= 1'b0;
            used_reg       <= '0;
        end
        else
        begin
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            vict_found_reg <= vict_found_next;
            used_reg       <= used_next;
        end
    end

    // captured indices, keys and counts
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        vict_idx_reg <= vict_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        vict_cnt_reg <= vict_cnt_next;
        vict_key_reg <= vict_key_next;
    end

    // summary outputs
    always_comb
    begin
        res.hit          = hit_reg;
        res.free_found   = free_found_reg;
        res.victim_found = vict_found_reg;
        res.hit_count    = hit_cnt_reg;
        res.victim_key   = vict_key_reg;
    end
    assign hit_idx    = hit_idx_reg;
    assign free_idx   = free_idx_reg;
    assign victim_idx = vict_idx_reg;
    assign used       = used_reg;

    // checks
    `ASSERT_SAME(a_used_bounded, 1'b1, used_reg <= CNT_W'(SLOTS))
    `ASSERT_SAME(a_victim_needs_entry, vict_found_reg, used_reg != '0)

endmodule

// ===== sv/lfu_keyed_cache_table.sv =====
// ----------------------------------------------------------------------------
// lfu_keyed_cache_table
// Keyed table of SLOTS entries with use counts and least-used replacement
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one request (opcode, font_key, force_evict); m_axis_*
//   returns exactly one result per request (status, slot, evicted key, count).
//   cfg_valid/cfg_data writes the capacity limit; write it only while idle.
// Timing:
//   create, get and release scan every slot through the single key/count
//   memory read port, one slot a cycle, then pass the drain and decide
//   states; the result is registered from the decide state. The next request
//   is taken only once the sequencer is back in idle.
//   Release-all skips the scan and goes straight to the decide state.
// Reset:
//   all valid bits clear at once and the limit returns to 32; no clearing
//   pass is needed, so requests are taken right after reset.
// Stall:
//   a finished result sits in the output register; a new request may be taken
//   meanwhile, and its result waits in the decide step until the output frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_keyed_cache_table #(
    parameter int SLOTS = lfu_pkg::SLOTS_DEF   // 2 .. 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // capacity limit write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lfu_pkg::LIMIT_W-1:0]  cfg_data,
    // request channel
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [39:0]                  s_axis_tdata,  // opcode, font_key, force_evict, pad
    // result channel
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [71:0]                  m_axis_tdata   // status, slot_index, evicted_key,
                                                        // use_count_out
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > lfu_pkg::LIMIT_W) ? CNT_W : lfu_pkg::LIMIT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                addr_reg;
    logic [lfu_pkg::LIMIT_W-1:0]     limit_reg;
    logic [lfu_pkg::OP_W-1:0]        op_reg;
    logic [lfu_pkg::KEY_W-1:0]       key_reg;
    logic                            force_reg;
    logic [SLOTS-1:0]                valid_reg, valid_next;

    // table memories
    logic [lfu_pkg::KEY_W-1:0]       key_mem [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0]     cnt_mem [SLOTS];
    logic [lfu_pkg::KEY_W-1:0]       rd_key_reg;
    logic [lfu_pkg::COUNT_W-1:0]     rd_cnt_reg;
    logic                            rd_valid_reg;
    logic                            rd_live_reg;
    logic [IDX_W-1:0]                rd_idx_reg;

    // scan unit interface
    lfu_pkg::sample_t                sample;
    lfu_pkg::scan_res_t              res;
    logic [IDX_W-1:0]                hit_idx, free_idx, victim_idx;
    logic [CNT_W-1:0]                used;

    // decide step
    logic                            accept;
    logic                            out_free;
    logic                            done;
    logic [CMP_W-1:0]                limit_ext, slots_ext, eff_limit, used_ext;
    logic [lfu_pkg::COUNT_W-1:0]     bumped;
    logic [lfu_pkg::STATUS_W-1:0]    st_d;
    logic [IDX_W-1:0]                slot_d;
    logic                            slot_zero;
    logic [lfu_pkg::KEY_W-1:0]       evk_d;
    logic [lfu_pkg::COUNT_W-1:0]     cnt_d;
    logic                            wr_key_en, wr_cnt_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [lfu_pkg::COUNT_W-1:0]     wr_cnt;
    logic [IDX_W+4:0]                slot_wide;

    // output register
    logic                            m_valid_reg;
    logic [71:0]                     m_data_reg;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign done          = (state_reg == S_DECIDE) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tdata[1:0] == lfu_pkg::OP_CLEAR)
                        state_next = S_DECIDE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            addr_reg    <= '0;
            limit_reg   <= lfu_pkg::LIMIT_RST;
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rd_live_reg <= (state_reg == S_SCAN);
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (accept)
                addr_reg <= '0;
            else if (state_reg == S_SCAN && addr_reg != LAST_IDX)
                addr_reg <= addr_reg + IDX_W'(1);
            if (done)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_axis_tdata[1:0];
            key_reg   <= s_axis_tdata[33:2];
            force_reg <= s_axis_tdata[34];
        end
    end

    // key and count memories: one read and one write port
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[addr_reg];
        rd_cnt_reg   <= cnt_mem[addr_reg];
        rd_valid_reg <= valid_reg[addr_reg];
        rd_idx_reg   <= addr_reg;
        if (wr_key_en)
            key_mem[wr_addr] <= key_reg;
        if (wr_cnt_en)
            cnt_mem[wr_addr] <= wr_cnt;
    end

    // slot stream into the compare unit
    always_comb
    begin
        sample.live  = rd_live_reg;
        sample.valid = rd_valid_reg;
        sample.key   = rd_key_reg;
        sample.count = rd_cnt_reg;
    end

    lfu_scan #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .req_key    (key_reg),
        .sample     (sample),
        .sample_idx (rd_idx_reg),
        .res        (res),
        .hit_idx    (hit_idx),
        .free_idx   (free_idx),
        .victim_idx (victim_idx),
        .used       (used)
    );

    // effective capacity and saturating count
    assign limit_ext = CMP_W'(limit_reg);
    assign slots_ext = CMP_W'(SLOTS);
    assign eff_limit = (limit_ext < slots_ext) ? limit_ext : slots_ext;
    assign used_ext  = CMP_W'(used);
    assign bumped    = (res.hit_count == '1) ? res.hit_count
                                             : res.hit_count + lfu_pkg::COUNT_W'(1);

    // decide the outcome and the table update
    always_comb
    begin
        st_d       = lfu_pkg::ST_CLEARED;
        slot_d     = '0;
        slot_zero  = 1'b1;
        evk_d      = '0;
        cnt_d      = '0;
        wr_key_en  = 1'b0;
        wr_cnt_en  = 1'b0;
        wr_addr    = hit_idx;
        wr_cnt     = bumped;
        valid_next = valid_reg;
        if (op_reg == lfu_pkg::OP_CLEAR)
        begin
            if (done)
                valid_next = '0;
        end
        else if (op_reg == lfu_pkg::OP_RELEASE)
        begin
            if (res.hit)
            begin
                st_d      = lfu_pkg::ST_RELEASED;
                slot_d    = hit_idx;
                slot_zero = 1'b0;
                if (done)
                    valid_next[hit_idx] = 1'b0;
            end
            else
            begin
                st_d = lfu_pkg::ST_REL_MISS;
            end
        end
        else if (res.hit)
        begin
            st_d      = lfu_pkg::ST_HIT;
            slot_d    = hit_idx;
            slot_zero = 1'b0;
            cnt_d     = bumped;
            wr_cnt_en = done;
        end
        else if (op_reg == lfu_pkg::OP_GET)
        begin
            st_d = lfu_pkg::ST_MISS;
        end
        else if (used_ext < eff_limit && res.free_found)
        begin
            // insert at the lowest free slot
            st_d      = lfu_pkg::ST_INSERTED;
            slot_d    = free_idx;
            slot_zero = 1'b0;
            cnt_d     = lfu_pkg::COUNT_W'(1);
            wr_addr   = free_idx;
            wr_cnt    = lfu_pkg::COUNT_W'(1);
            wr_key_en = done;
            wr_cnt_en = done;
            if (done)
                valid_next[free_idx] = 1'b1;
        end
        else if (!force_reg || !res.victim_found)
        begin
            st_d = lfu_pkg::ST_REFUSED;
        end
        else
        begin
            // replace the least used entry in place
            st_d      = lfu_pkg::ST_EVICTED;
            slot_d    = victim_idx;
            slot_zero = 1'b0;
            evk_d     = res.victim_key;
            cnt_d     = lfu_pkg::COUNT_W'(1);
            wr_addr   = victim_idx;
            wr_cnt    = lfu_pkg::COUNT_W'(1);
            wr_key_en = done;
            wr_cnt_en = done;
        end
    end

    // slot number reported in five bits
    assign slot_wide = {5'd0, (slot_zero ? IDX_W'(0) : slot_d)};

    // result register
    always_ff @(posedge clk)
    begin
        if (done)
            m_data_reg <= {cnt_d, evk_d, slot_wide[4:0], st_d};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    `ASSERT_NEXT(a_decide_holds, state_reg == S_DECIDE && !out_free, state_reg == S_DECIDE)
    `ASSERT_NEXT(a_clear_empties, done && op_reg == lfu_pkg::OP_CLEAR, valid_reg == '0)
    `ASSERT_SAME(a_write_only_at_done, wr_key_en || wr_cnt_en, done)
    `ASSERT_NEXT(a_done_loads_output, done, m_valid_reg)

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed LFU cache table: a small tracker class
// keeps its own copy of the slots and the capacity limit, predicts one reply
// per accepted request and checks every reply field against it. A directed
// run of hits, misses, releases, clears, refusals and evictions comes first,
// then random phases under several capacity limits (zero, one and values
// above the slot count among them) with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    // one predicted reply
    typedef struct {
        logic [lfu_pkg::STATUS_W-1:0] status;
        logic [lfu_pkg::SLOT_W-1:0]   slot;
        logic [lfu_pkg::KEY_W-1:0]    evicted;
        logic [lfu_pkg::COUNT_W-1:0]  uses;
    } reply_t;

    // tracks the table contents and the replies still owed by the block
    class lfu_tracker;
        bit                          live [lfu_pkg::SLOTS_DEF];
        logic [lfu_pkg::KEY_W-1:0]   keys [lfu_pkg::SLOTS_DEF];
        logic [lfu_pkg::COUNT_W-1:0] uses [lfu_pkg::SLOTS_DEF];
        logic [lfu_pkg::LIMIT_W-1:0] limit;
        reply_t                      owed_replies[$];
        int                          errors;
        int                          requests;
        int                          tally [8];

        function new();
            limit = lfu_pkg::LIMIT_RST;
            foreach (live[i])
            begin
                live[i] = 1'b0;
                keys[i] = '0;
                uses[i] = '0;
            end
            foreach (tally[i])
                tally[i] = 0;
            errors   = 0;
            requests = 0;
        endfunction

        function void set_limit(logic [lfu_pkg::LIMIT_W-1:0] value);
            limit = value;
        endfunction

        // predict the reply for one accepted request and update the table
        function void log_request(logic [lfu_pkg::OP_W-1:0] op,
                                  logic [lfu_pkg::KEY_W-1:0] key, logic frc);
            reply_t r;
            int     hit_at;
            int     free_at;
            int     victim;
            int     used;
            int     cap;
            r.status  = lfu_pkg::ST_CLEARED;
            r.slot    = '0;
            r.evicted = '0;
            r.uses    = '0;
            hit_at    = -1;
            free_at   = -1;
            victim    = -1;
            used      = 0;
            requests++;
            if (op == lfu_pkg::OP_CLEAR)
            begin
                foreach (live[i])
                    live[i] = 1'b0;
            end
            else
            begin
                for (int i = 0; i < lfu_pkg::SLOTS_DEF; i++)
                    if (live[i] && keys[i] == key && hit_at < 0)
                        hit_at = i;
                if (op == lfu_pkg::OP_RELEASE)
                begin
                    if (hit_at < 0)
                        r.status = lfu_pkg::ST_REL_MISS;
                    else
                    begin
                        live[hit_at] = 1'b0;
                        r.status     = lfu_pkg::ST_RELEASED;
                        r.slot       = hit_at[lfu_pkg::SLOT_W-1:0];
                    end
                end
                else if (hit_at >= 0)
                begin
                    // saturating use count
                    if (uses[hit_at] != '1)
                        uses[hit_at]++;
                    r.status = lfu_pkg::ST_HIT;
                    r.slot   = hit_at[lfu_pkg::SLOT_W-1:0];
                    r.uses   = uses[hit_at];
                end
                else if (op == lfu_pkg::OP_GET)
                    r.status = lfu_pkg::ST_MISS;
                else
                begin
                    // occupancy, lowest free slot and least used victim
                    for (int i = 0; i < lfu_pkg::SLOTS_DEF; i++)
                    begin
                        if (live[i])
                        begin
                            used++;
                            if (victim < 0 || uses[i] < uses[victim])
                                victim = i;
                        end
                        else if (free_at < 0)
                            free_at = i;
                    end
                    cap = (limit > lfu_pkg::SLOTS_DEF) ? lfu_pkg::SLOTS_DEF : int'(limit);
                    if (used < cap && free_at >= 0)
                    begin
                        live[free_at] = 1'b1;
                        keys[free_at] = key;
                        uses[free_at] = 1;
                        r.status      = lfu_pkg::ST_INSERTED;
                        r.slot        = free_at[lfu_pkg::SLOT_W-1:0];
                        r.uses        = 1;
                    end
                    else if (!frc || victim < 0)
                        r.status = lfu_pkg::ST_REFUSED;
                    else
                    begin
                        r.evicted    = keys[victim];
                        keys[victim] = key;
                        uses[victim] = 1;
                        r.status     = lfu_pkg::ST_EVICTED;
                        r.slot       = victim[lfu_pkg::SLOT_W-1:0];
                        r.uses       = 1;
                    end
                end
            end
            owed_replies.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one reply from the block with the oldest prediction
        function void check_reply(logic [71:0] data);
            reply_t want;
            if (owed_replies.size() == 0)
            begin
                $display("%0t: reply with no request pending, expected none, actual %h",
                         $time, data);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            tally[want.status]++;
            compare("status", 32'(want.status), 32'(data[2:0]));
            compare("slot_index", 32'(want.slot), 32'(data[7:3]));
            compare("evicted_key", want.evicted, data[39:8]);
            compare("use_count_out", want.uses, data[71:40]);
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [lfu_pkg::LIMIT_W-1:0]  cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [39:0]                  s_axis_tdata;   // opcode, font_key, force_evict, pad
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [71:0]                  m_axis_tdata;   // status, slot_index, evicted_key,
                                                  // use_count_out

    lfu_tracker                board = new();
    bit                        idle_on;
    int                        stall_left;
    int                        phases;
    logic [lfu_pkg::KEY_W-1:0] key_pool [48];

    lfu_keyed_cache_table #(.SLOTS(lfu_pkg::SLOTS_DEF)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always #4 clk = ~clk;

    // result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // reply check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reply(m_axis_tdata);
    end

    // hard limit on run length
    initial
    begin
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

    // present one request, called and returning at a falling edge
    task automatic send_request(logic [lfu_pkg::OP_W-1:0] op,
                                logic [lfu_pkg::KEY_W-1:0] key, logic frc);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, frc, key, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.log_request(op, key, frc);
        @(negedge clk);
    endtask

    // stop sending and wait for every owed reply
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.owed_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // capacity limit write, only while idle
    task automatic write_limit(logic [lfu_pkg::LIMIT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_limit(value);
        phases++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random requests over a key pool sized to the current capacity
    task automatic random_phase(int count);
        int                        span;
        int                        r;
        logic [lfu_pkg::OP_W-1:0]  op;
        logic [lfu_pkg::KEY_W-1:0] key;
        span = ((board.limit > lfu_pkg::SLOTS_DEF) ? lfu_pkg::SLOTS_DEF
                                                   : int'(board.limit)) + 5;
        if (span > 48)
            span = 48;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = lfu_pkg::OP_CREATE;
            else if (r < 75)
                op = lfu_pkg::OP_GET;
            else if (r < 93)
                op = lfu_pkg::OP_RELEASE;
            else
                op = lfu_pkg::OP_CLEAR;
            if ($urandom_range(0, 4) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, span - 1)];
            send_request(op, key, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [lfu_pkg::LIMIT_W-1:0] limits [10];
        int                          errors;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_on       = 1'b1;
        stall_left    = 0;
        phases        = 1;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        limits = '{6'd4, 6'd1, 6'd63, 6'd0, 6'd40, 6'd2, 6'd17, 6'd0, 6'd6, 6'd32};
        limits[7] = lfu_pkg::LIMIT_W'($urandom_range(0, 63));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hit, miss, release and clear at the reset limit
        send_request(lfu_pkg::OP_CREATE, 32'h0000_0000, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'hFFFF_FFFF, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'h0000_0000, 1'b1);
        send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 1'b0);
        send_request(lfu_pkg::OP_GET, 32'h1234_5678, 1'b1);
        send_request(lfu_pkg::OP_RELEASE, 32'h0000_0000, 1'b0);
        send_request(lfu_pkg::OP_RELEASE, 32'h0000_0000, 1'b1);
        send_request(lfu_pkg::OP_CREATE, 32'hA5A5_A5A5, 1'b1);
        send_request(lfu_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 1'b0);

        // full table: refusal, then least used eviction
        write_limit(6'd2);
        send_request(lfu_pkg::OP_CREATE, 32'h5A5A_5A5A, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'h0F0F_0F0F, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'hF0F0_F0F0, 1'b0);
        send_request(lfu_pkg::OP_GET, 32'h5A5A_5A5A, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'hF0F0_F0F0, 1'b1);
        send_request(lfu_pkg::OP_CREATE, 32'h3C3C_3C3C, 1'b1);

        // limit lowered below occupancy
        write_limit(6'd1);
        send_request(lfu_pkg::OP_CREATE, 32'hC3C3_C3C3, 1'b1);
        send_request(lfu_pkg::OP_CREATE, 32'hC3C3_C3C3, 1'b0);

        // zero capacity, with and without anything to evict
        write_limit(6'd0);
        send_request(lfu_pkg::OP_CREATE, 32'h1111_1111, 1'b0);
        send_request(lfu_pkg::OP_CLEAR, 32'h0000_0000, 1'b0);
        send_request(lfu_pkg::OP_CREATE, 32'h2222_2222, 1'b1);
        send_request(lfu_pkg::OP_CREATE, 32'h2222_2222, 1'b0);

        // limit above the slot count
        write_limit(6'd63);
        send_request(lfu_pkg::OP_CREATE, 32'h3333_3333, 1'b0);

        // random phases, the last one with no idling
        for (int p = 0; p < 10; p++)
        begin
            write_limit(limits[p]);
            idle_on = (p == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
            random_phase(100);
        end

        drain();
        repeat (lfu_pkg::SLOTS_DEF + 8) @(posedge clk);

        errors = board.errors + board.owed_replies.size();
        $display("covered %0d requests over %0d limit settings: %0d hits, %0d inserts, %s",
                 board.requests, phases, board.tally[lfu_pkg::ST_HIT],
                 board.tally[lfu_pkg::ST_INSERTED],
                 $sformatf("%0d evictions, %0d refusals", board.tally[lfu_pkg::ST_EVICTED],
                           board.tally[lfu_pkg::ST_REFUSED]));
        $display("also %0d misses, %0d releases, %0d release misses, %0d clears; %0d errors",
                 board.tally[lfu_pkg::ST_MISS], board.tally[lfu_pkg::ST_RELEASED],
                 board.tally[lfu_pkg::ST_REL_MISS], board.tally[lfu_pkg::ST_CLEARED],
                 errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
